// ===== hw/rtl/rhc_pkg.sv =====
// Shared package for the RGB/HSL colour converter: field widths, mode codes,
// fixed-point constants and the reciprocal table used by the RGB-to-HSL divisions.
// No dependencies.
`timescale 1ns / 1ps

package rhc_pkg;

    // Direction codes held in the mode register.
    localparam logic MODE_TO_HSL = 1'b0;
    localparam logic MODE_TO_RGB = 1'b1;

    // Number of register stages in each conversion path.
    localparam int PIPE_DEPTH = 5;

    // One 60-degree sector in 1/64-degree hue units, and one in Q0.12.
    localparam int SECTOR_UNITS = 3840;
    localparam int ONE_Q12      = 4096;

    // Reciprocals are floor(2^RECIP_SHIFT / d) for an 8-bit divisor d.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    typedef logic [RECIP_W-1:0] t_recip_tab [256];

    // Built at elaboration with a restoring division, so no divider is inferred.
    function automatic t_recip_tab build_recip_tab();
        t_recip_tab           tab;
        logic [RECIP_W:0]     rem;
        logic [RECIP_W-1:0]   quo;
        int                   d;
        int                   b;
        tab[0] = '0;
        for (d = 1; d < 256; d++) begin
            rem = '0;
            quo = '0;
            for (b = RECIP_SHIFT; b >= 0; b--) begin
                rem = {rem[RECIP_W-1:0], (b == RECIP_SHIFT) ? 1'b1 : 1'b0};
                if (rem >= (RECIP_W+1)'(d)) begin
                    rem    = rem - (RECIP_W+1)'(d);
                    quo[b] = 1'b1;
                end
            end
            tab[d] = quo;
        end
        return tab;
    endfunction

    localparam t_recip_tab RECIP_TAB = build_recip_tab();

endpackage

// ===== hw/rtl/rhc_hsl_path.sv =====
// RGB-to-HSL conversion path: five register stages from bytes to hue,
// saturation and lightness. Depends on rhc_pkg for the reciprocal table.
`timescale 1ns / 1ps

module rhc_hsl_path (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic [14:0] o_hue,
    output logic [12:0] o_sat,
    output logic [12:0] o_light
);

    localparam logic [24:0] RECIP_255 = rhc_pkg::RECIP_TAB[255];

    // Stage 1: extremes, chroma and the hue numerator.
    logic [7:0]  mx, mn, c1, den1;
    logic [8:0]  sum1;
    logic [10:0] num1;
    logic [7:0]  r1_c, r1_den;
    logic [8:0]  r1_sum;
    logic [10:0] r1_num;
    logic        r1_zh, r1_zs;

    always_comb begin
        mx = (i_red > i_green) ? i_red : i_green;
        mx = (mx > i_blue) ? mx : i_blue;
        mn = (i_red < i_green) ? i_red : i_green;
        mn = (mn < i_blue) ? mn : i_blue;
        c1 = mx - mn;
        sum1 = {1'b0, mx} + {1'b0, mn};
        num1 = '0;
        if (c1 != 8'd0) begin
            if (mx == i_red) begin
                num1 = (i_blue > i_green)
                     ? 11'(3'd6 * c1) - 11'(i_blue - i_green)
                     : 11'(i_green - i_blue);
            end else if (mx == i_green) begin
                num1 = 11'({c1, 1'b0}) + 11'(i_blue) - 11'(i_red);
            end else begin
                num1 = 11'({c1, 2'b00}) + 11'(i_red) - 11'(i_green);
            end
        end
        den1 = (sum1 <= 9'd255) ? sum1[7:0] : 8'(9'd510 - sum1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_c   <= c1;
            r1_den <= den1;
            r1_sum <= sum1;
            r1_num <= num1;
            r1_zh  <= (c1 == 8'd0);
            r1_zs  <= (sum1 == 9'd0) || (sum1 == 9'd510);
        end
    end

    // Stage 2: dividends and reciprocal lookups.
    logic [22:0] r2_hn;
    logic [19:0] r2_sn, r2_ln;
    logic [24:0] r2_hr, r2_sr;
    logic [7:0]  r2_hd, r2_sd;
    logic        r2_zh, r2_zs;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_hn <= 23'({r1_num, 12'd0}) - 23'({r1_num, 8'd0});
            r2_sn <= {r1_c, 12'd0};
            r2_ln <= {r1_sum, 11'd0};
            r2_hr <= rhc_pkg::RECIP_TAB[r1_c];
            r2_sr <= rhc_pkg::RECIP_TAB[r1_den];
            r2_hd <= r1_c;
            r2_sd <= r1_den;
            r2_zh <= r1_zh;
            r2_zs <= r1_zs;
        end
    end

    // Stage 3: quotient estimates, at most one short of the true quotient.
    logic [47:0] hp;
    logic [44:0] sp, lp;
    logic [14:0] r3_hq;
    logic [12:0] r3_sq, r3_lq;
    logic [22:0] r3_hn;
    logic [19:0] r3_sn, r3_ln;
    logic [7:0]  r3_hd, r3_sd;
    logic        r3_zh, r3_zs;

    always_comb begin
        hp = r2_hn * r2_hr;
        sp = r2_sn * r2_sr;
        lp = r2_ln * RECIP_255;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_hq <= hp[38:24];
            r3_sq <= sp[36:24];
            r3_lq <= lp[36:24];
            r3_hn <= r2_hn;
            r3_sn <= r2_sn;
            r3_ln <= r2_ln;
            r3_hd <= r2_hd;
            r3_sd <= r2_sd;
            r3_zh <= r2_zh;
            r3_zs <= r2_zs;
        end
    end

    // Stage 4: remainder check and correction.
    logic [22:0] hrem;
    logic [19:0] srem, lrem;
    logic [14:0] r4_hq;
    logic [12:0] r4_sq, r4_lq;
    logic        r4_zh, r4_zs;

    always_comb begin
        hrem = r3_hn - 23'(r3_hq * r3_hd);
        srem = r3_sn - 20'(r3_sq * r3_sd);
        lrem = r3_ln - 20'(r3_lq * 8'd255);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_hq <= r3_hq + 15'(hrem >= 23'(r3_hd));
            r4_sq <= r3_sq + 13'(srem >= 20'(r3_sd));
            r4_lq <= r3_lq + 13'(lrem >= 20'd255);
            r4_zh <= r3_zh;
            r4_zs <= r3_zs;
        end
    end

    // Stage 5: grey pixels have no hue, black and white have no saturation.
    logic [14:0] r5_hue;
    logic [12:0] r5_sat, r5_light;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_hue   <= r4_zh ? 15'd0 : r4_hq;
            r5_sat   <= r4_zs ? 13'd0 : r4_sq;
            r5_light <= r4_lq;
        end
    end

    assign o_hue   = r5_hue;
    assign o_sat   = r5_sat;
    assign o_light = r5_light;

endmodule

// ===== hw/rtl/rhc_rgb_path.sv =====
// HSL-to-RGB conversion path: five register stages from hue, saturation
// and lightness to rounded, saturated bytes. Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_rgb_path (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [14:0] i_hue,
    input  logic [12:0] i_sat,
    input  logic [12:0] i_light,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);

    localparam logic [12:0] ONE    = 13'(rhc_pkg::ONE_Q12);
    localparam logic [14:0] SECTOR = 15'(rhc_pkg::SECTOR_UNITS);
    localparam logic [45:0] HALF   = 46'(15) << 31;
    localparam logic [12:0] RECIP_15 = 13'd4370;

    // Stage 1: clamp, chroma (units of 2^-24), sector and neighbour weight.
    logic [12:0] sc, lc;
    logic [11:0] lf, f1, k1;
    logic [24:0] c2;
    logic [3:0]  sec1;
    logic [24:0] r1_c2;
    logic [12:0] r1_l;
    logic [3:0]  r1_sec;
    logic [11:0] r1_k;

    always_comb begin
        sc  = (i_sat > ONE) ? ONE : i_sat;
        lc  = (i_light > ONE) ? ONE : i_light;
        lf  = (lc <= (ONE >> 1)) ? lc[11:0] : 12'(ONE - lc);
        c2  = {24'(lf * sc), 1'b0};
        sec1 = '0;
        for (int j = 1; j <= 8; j++) begin
            if (i_hue >= 15'(j * rhc_pkg::SECTOR_UNITS)) begin
                sec1 = 4'(j);
            end
        end
        f1 = 12'(i_hue - 15'(sec1 * SECTOR));
        k1 = sec1[0] ? 12'(SECTOR - 15'(f1)) : f1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_c2  <= c2;
            r1_l   <= lc;
            r1_sec <= sec1;
            r1_k   <= k1;
        end
    end

    // Stage 2: the two chroma terms and the offset l - c/2, all scaled by 3840.
    logic [36:0] r2_xs, r2_cs, r2_base;
    logic [3:0]  r2_sec;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_xs   <= 37'(r1_c2 * r1_k);
            r2_cs   <= (37'(r1_c2) << 12) - (37'(r1_c2) << 8);
            r2_base <= (((37'(r1_l) << 4) - 37'(r1_l)) << 20)
                     - ((37'(r1_c2) << 11) - (37'(r1_c2) << 7));
            r2_sec  <= r1_sec;
        end
    end

    // Stage 3: place the terms on the channels for this sector.
    logic [36:0] tr, tg, tb;
    logic [37:0] r3_val [3];

    always_comb begin
        tr = '0;
        tg = '0;
        tb = '0;
        unique case (r2_sec)
            4'd0: begin tr = r2_cs; tg = r2_xs; end
            4'd1: begin tr = r2_xs; tg = r2_cs; end
            4'd2: begin tg = r2_cs; tb = r2_xs; end
            4'd3: begin tg = r2_xs; tb = r2_cs; end
            4'd4: begin tr = r2_xs; tb = r2_cs; end
            4'd5: begin tr = r2_cs; tb = r2_xs; end
            default: begin end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_val[0] <= 38'(r2_base) + 38'(tr);
            r3_val[1] <= 38'(r2_base) + 38'(tg);
            r3_val[2] <= 38'(r2_base) + 38'(tb);
        end
    end

    // Stage 4: scale by 255, add half an LSB, drop 2^32 of the 15 * 2^32 divisor.
    logic [45:0] t4 [3];
    logic [11:0] r4_x [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            t4[ch] = (46'(r3_val[ch]) << 8) - 46'(r3_val[ch]) + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                r4_x[ch] <= t4[ch][43:32];
            end
        end
    end

    // Stage 5: divide by 15 through a reciprocal, exact for 12-bit values, and clamp.
    logic [24:0] p5 [3];
    logic [7:0]  r5_byte [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            p5[ch] = r4_x[ch] * RECIP_15;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                r5_byte[ch] <= p5[ch][24] ? 8'd255 : p5[ch][23:16];
            end
        end
    end

    assign o_red   = r5_byte[0];
    assign o_green = r5_byte[1];
    assign o_blue  = r5_byte[2];

endmodule

// ===== hw/rtl/rgb_hsl_color_converter_core.sv =====
// RGB/HSL colour converter top level: mode register, valid and mode pipeline,
// and output selection. Depends on rhc_pkg, rhc_hsl_path and rhc_rgb_path.
`timescale 1ns / 1ps

// Converts one pixel per clock between 8-bit RGB and HSL while the output is
// not stalled, with the direction set by a one-bit mode register (0 gives hue
// in 1/64-degree steps and saturation and lightness in Q0.12; 1 gives
// saturated RGB bytes). A new transfer may be accepted on every cycle in which
// the pipe advances; each transfer passes through the five register stages of
// the two conversion paths, which share one advance enable. When a finished
// transfer is held at the output by i_stall the whole pipeline freezes and
// o_stall is raised, so nothing is lost or repeated; bubbles are never squeezed
// out, as the pipe only ever moves as one. The fields of the direction not
// selected read as zero. Change the mode only while no transfer is in flight;
// each transfer carries the mode it was accepted with.
module rgb_hsl_color_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [14:0] i_hue_in,
    input  logic [12:0] i_saturation_in,
    input  logic [12:0] i_lightness_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [14:0] o_hue_out,
    output logic [12:0] o_saturation_out,
    output logic [12:0] o_lightness_out
);

    localparam int DEPTH = rhc_pkg::PIPE_DEPTH;

    logic             r_mode_cfg;
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] r_mode;
    logic             adv;

    // The pipe advances unless a finished transfer is being held at the output.
    assign adv     = !r_vld[DEPTH-1] || !i_stall;
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_cfg <= rhc_pkg::MODE_TO_HSL;
        end else if (i_cfg_wr_en) begin
            r_mode_cfg <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_mode <= '0;
        end else if (adv) begin
            r_vld  <= {r_vld[DEPTH-2:0], i_valid};
            r_mode <= {r_mode[DEPTH-2:0], r_mode_cfg};
        end
    end

    logic [14:0] hsl_hue;
    logic [12:0] hsl_sat, hsl_light;
    logic [7:0]  rgb_red, rgb_green, rgb_blue;

    rhc_hsl_path u_hsl (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_hue   (hsl_hue),
        .o_sat   (hsl_sat),
        .o_light (hsl_light)
    );

    rhc_rgb_path u_rgb (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_hue   (i_hue_in),
        .i_sat   (i_saturation_in),
        .i_light (i_lightness_in),
        .o_red   (rgb_red),
        .o_green (rgb_green),
        .o_blue  (rgb_blue)
    );

    logic out_rgb;
    assign out_rgb = (r_mode[DEPTH-1] == rhc_pkg::MODE_TO_RGB);

    assign o_valid          = r_vld[DEPTH-1];
    assign o_red_out        = out_rgb ? rgb_red   : 8'd0;
    assign o_green_out      = out_rgb ? rgb_green : 8'd0;
    assign o_blue_out       = out_rgb ? rgb_blue  : 8'd0;
    assign o_hue_out        = out_rgb ? 15'd0 : hsl_hue;
    assign o_saturation_out = out_rgb ? 13'd0 : hsl_sat;
    assign o_lightness_out  = out_rgb ? 13'd0 : hsl_light;

endmodule
